// File: src/pfde_pkg.sv
// Package for the page framebuffer draw engine.
// Holds command codes, controller states, coordinate widths and reset values.
// No dependencies.
package pfde_pkg;

  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 64;

  // coordinate widths wide enough for every supported geometry
  localparam int XC_W = 9;
  localparam int YC_W = 8;
  localparam int PG_W = 5;

  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 8;

  localparam logic [7:0] DISP_WIDTH_RST  = 8'd128;
  localparam logic [6:0] DISP_HEIGHT_RST = 7'd64;

  // row within a page
  localparam logic [2:0] PAGE_ROW_MASK = 3'h7;

  typedef enum logic [1:0] {
    CMD_PIXEL = 2'd0,
    CMD_RECT  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_DISP_WIDTH  = 1'b0,
    REG_DISP_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_CLEAR,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_DONE
  } state_t;

endpackage

// File: src/page_framebuffer_draw_engine.sv
// Page framebuffer draw engine: pixel, rectangle, clear and read on a paged store.
// A pixel passes read, write and done states, a read passes address, data and done (only
// done when off display); a rectangle does a read-modify-write per page byte it touches.
// One request at a time; the bound is the read-modify-write over the single RAM port.
// Clear all writes every store byte in turn. After reset the store is swept to zero with
// s_axis_tready low; configuration writes are taken at any time.
module page_framebuffer_draw_engine
  import pfde_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_data,
  // request stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // pos_x[6:0], pos_y[12:7], rect_w[20:13], rect_h[27:21]
  input  logic [S_TUSER_W-1:0] s_axis_tuser,  // cmd[1:0], inverse[2]
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // read_byte[7:0]
  output logic                 m_axis_tuser   // in_bounds[0]
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT / 8;
  localparam int AW     = $clog2(DEPTH);
  localparam int PROD_W = XC_W + PG_W;

  // request fields
  logic [6:0] pos_x;
  logic [5:0] pos_y;
  logic [7:0] rect_w;
  logic [6:0] rect_h;
  cmd_t       cmd;
  logic       inverse;

  assign pos_x   = s_axis_tdata[6:0];
  assign pos_y   = s_axis_tdata[12:7];
  assign rect_w  = s_axis_tdata[20:13];
  assign rect_h  = s_axis_tdata[27:21];
  assign cmd     = cmd_t'(s_axis_tuser[1:0]);
  assign inverse = s_axis_tuser[2];

  // registers
  state_t          state, state_next;
  logic [AW-1:0]   clr_cnt, clr_cnt_next;
  logic [7:0]      disp_width;
  logic [6:0]      disp_height;
  logic [XC_W-1:0] cur_x, cur_x_next;
  logic [XC_W-1:0] x_first, x_first_next;
  logic [XC_W-1:0] x_last, x_last_next;
  logic [PG_W-1:0] cur_page, cur_page_next;
  logic [YC_W-1:0] y_first, y_first_next;
  logic [YC_W-1:0] y_last, y_last_next;
  logic            clr, clr_next;
  logic [7:0]      res_byte, res_byte_next;
  logic            res_inb, res_inb_next;
  logic            m_tvalid_next;
  logic [7:0]      m_tdata_next;
  logic            m_tuser_next;

  // memory port
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  pfde_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  // effective geometry
  logic [XC_W-1:0] eff_w;
  logic [YC_W-1:0] eff_h;

  assign eff_w = ({1'b0, disp_width} < XC_W'(MAX_WIDTH)) ? XC_W'(disp_width)
                                                         : XC_W'(MAX_WIDTH);
  assign eff_h = (YC_W'(disp_height) < YC_W'(MAX_HEIGHT)) ? YC_W'(disp_height)
                                                          : YC_W'(MAX_HEIGHT);

  // clipping of a new request
  logic [XC_W-1:0] in_x;
  logic [YC_W-1:0] in_y;
  logic [XC_W-1:0] x_end_raw, x_end;
  logic [YC_W-1:0] y_end_raw, y_end;
  logic            on_disp;
  logic            rect_empty;

  assign in_x       = XC_W'(pos_x);
  assign in_y       = YC_W'(pos_y);
  assign x_end_raw  = in_x + XC_W'(rect_w);
  assign y_end_raw  = in_y + YC_W'(rect_h);
  assign x_end      = (x_end_raw < eff_w) ? x_end_raw : eff_w;
  assign y_end      = (y_end_raw < eff_h) ? y_end_raw : eff_h;
  assign on_disp    = (in_x < eff_w) && (in_y < eff_h);
  assign rect_empty = (rect_w == 8'd0) || (rect_h == 7'd0) || !on_disp;

  // byte address and row mask for the current column and page
  logic [PROD_W-1:0] addr_full;
  logic [AW-1:0]     cur_addr;
  logic [PG_W-1:0]   page_first, page_last;
  logic [2:0]        row_lo, row_hi;
  logic [7:0]        row_mask;

  assign addr_full  = PROD_W'(eff_w) * PROD_W'(cur_page) + PROD_W'(cur_x);
  assign cur_addr   = addr_full[AW-1:0];
  assign page_first = y_first[YC_W-1:3];
  assign page_last  = y_last[YC_W-1:3];
  assign row_lo     = (cur_page == page_first) ? y_first[2:0] : 3'd0;
  assign row_hi     = (cur_page == page_last) ? y_last[2:0] : PAGE_ROW_MASK;
  assign row_mask   = (8'hFF << row_lo) & (8'hFF >> (PAGE_ROW_MASK - row_hi));

  logic out_free;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;

  always_comb begin
    state_next    = state;
    clr_cnt_next  = clr_cnt;
    cur_x_next    = cur_x;
    x_first_next  = x_first;
    x_last_next   = x_last;
    cur_page_next = cur_page;
    y_first_next  = y_first;
    y_last_next   = y_last;
    clr_next      = clr;
    res_byte_next = res_byte;
    res_inb_next  = res_inb;
    m_tvalid_next = m_axis_tvalid && !m_axis_tready;
    m_tdata_next  = m_axis_tdata;
    m_tuser_next  = m_axis_tuser;
    mem_we        = 1'b0;
    mem_addr      = cur_addr;
    mem_wdata     = 8'd0;

    unique case (state)
      ST_INIT: begin
        mem_we       = 1'b1;
        mem_addr     = clr_cnt;
        clr_cnt_next = clr_cnt + AW'(1);
        if (clr_cnt == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          res_byte_next = 8'd0;
          res_inb_next  = 1'b0;
          clr_next      = inverse;
          unique case (cmd)
            CMD_PIXEL: begin
              cur_x_next    = in_x;
              x_first_next  = in_x;
              x_last_next   = in_x;
              cur_page_next = in_y[YC_W-1:3];
              y_first_next  = in_y;
              y_last_next   = in_y;
              res_inb_next  = on_disp;
              state_next    = on_disp ? ST_RMW_RD : ST_DONE;
            end
            CMD_RECT: begin
              cur_x_next    = in_x;
              x_first_next  = in_x;
              x_last_next   = x_end - XC_W'(1);
              cur_page_next = in_y[YC_W-1:3];
              y_first_next  = in_y;
              y_last_next   = y_end - YC_W'(1);
              state_next    = rect_empty ? ST_DONE : ST_RMW_RD;
            end
            CMD_CLEAR: begin
              clr_cnt_next = '0;
              state_next   = ST_CLEAR;
            end
            CMD_READ: begin
              cur_x_next    = in_x;
              cur_page_next = in_y[YC_W-1:3];
              res_inb_next  = on_disp;
              state_next    = on_disp ? ST_RD_ADDR : ST_DONE;
            end
          endcase
        end
      end
      ST_RMW_RD: begin
        state_next = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        mem_we    = 1'b1;
        mem_wdata = clr ? (mem_rdata & ~row_mask) : (mem_rdata | row_mask);
        // columns inner, pages outer
        if (cur_x == x_last) begin
          if (cur_page == page_last) begin
            state_next = ST_DONE;
          end else begin
            cur_x_next    = x_first;
            cur_page_next = cur_page + PG_W'(1);
            state_next    = ST_RMW_RD;
          end
        end else begin
          cur_x_next = cur_x + XC_W'(1);
          state_next = ST_RMW_RD;
        end
      end
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_addr     = clr_cnt;
        clr_cnt_next = clr_cnt + AW'(1);
        if (clr_cnt == AW'(DEPTH - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_RD_ADDR: begin
        state_next = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        res_byte_next = mem_rdata;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = res_byte;
          m_tuser_next  = res_inb;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_INIT;
      clr_cnt       <= '0;
      m_axis_tvalid <= 1'b0;
      disp_width    <= DISP_WIDTH_RST;
      disp_height   <= DISP_HEIGHT_RST;
    end else begin
      state         <= state_next;
      clr_cnt       <= clr_cnt_next;
      m_axis_tvalid <= m_tvalid_next;
      if (cfg_valid) begin
        unique case (reg_idx_t'(cfg_index))
          REG_DISP_WIDTH:  disp_width  <= cfg_data;
          REG_DISP_HEIGHT: disp_height <= cfg_data[6:0];
        endcase
      end
    end
    cur_x        <= cur_x_next;
    x_first      <= x_first_next;
    x_last       <= x_last_next;
    cur_page     <= cur_page_next;
    y_first      <= y_first_next;
    y_last       <= y_last_next;
    clr          <= clr_next;
    res_byte     <= res_byte_next;
    res_inb      <= res_inb_next;
    m_axis_tdata <= m_tdata_next;
    m_axis_tuser <= m_tuser_next;
  end

endmodule

// File: src/pfde_ram.sv
// Generic single-port RAM with a registered read.
// No dependencies.
module pfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: dv/tb_page_framebuffer_draw_engine.sv
`timescale 1ns / 100ps
// Self-checking bench for page_framebuffer_draw_engine: a page store model predicts each result.
// Depends on pfde_pkg and the engine RTL; no files or arguments are read.
module tb_page_framebuffer_draw_engine;
  import pfde_pkg::*;

  localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT / 8;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 200;
  localparam int RAND_PHASES = 7;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       in_bounds;
  } page_result_t;

  // predicts the page store and the result of every request
  class page_store_model;
    logic [7:0]   store [STORE_DEPTH];
    int unsigned  disp_width;
    int unsigned  disp_height;
    page_result_t pending_results[$];
    int           mismatches;
    int           results_checked;

    function new();
      clear_store();
      disp_width      = 32'(DISP_WIDTH_RST);
      disp_height     = 32'(DISP_HEIGHT_RST);
      mismatches      = 0;
      results_checked = 0;
    endfunction

    function void clear_store();
      foreach (store[i]) store[i] = 8'h00;
    endfunction

    function void write_reg(reg_idx_t idx, logic [7:0] value);
      if (idx == REG_DISP_WIDTH) disp_width = 32'(value);
      else disp_height = 32'(value[6:0]);
    endfunction

    function int unsigned eff_w();
      return (disp_width < DEF_MAX_WIDTH) ? disp_width : DEF_MAX_WIDTH;
    endfunction

    function int unsigned eff_h();
      return (disp_height < DEF_MAX_HEIGHT) ? disp_height : DEF_MAX_HEIGHT;
    endfunction

    function bit on_display(int unsigned x, int unsigned y);
      return (x < eff_w()) && (y < eff_h());
    endfunction

    function int unsigned page_index(int unsigned x, int unsigned y);
      return (x + eff_w() * (y >> 3)) % STORE_DEPTH;
    endfunction

    function void paint(int unsigned x, int unsigned y, bit clr);
      int unsigned idx;
      logic [7:0]  mask;
      if (!on_display(x, y)) return;
      idx  = page_index(x, y);
      mask = 8'h01 << (y & PAGE_ROW_MASK);
      if (clr) store[idx] = store[idx] & ~mask;
      else store[idx] = store[idx] | mask;
    endfunction

    function void note_request(cmd_t cmd, logic [6:0] x, logic [5:0] y, logic [7:0] rw,
                               logic [6:0] rh, logic inv);
      page_result_t res;
      int unsigned  x_end;
      int unsigned  y_end;
      res = '0;
      case (cmd)
        CMD_PIXEL: begin
          res.in_bounds = on_display(x, y);
          paint(x, y, inv);
        end
        CMD_RECT: begin
          // clip to the display up front, pixels beyond it are skipped anyway
          x_end = (x + rw < eff_w()) ? x + rw : eff_w();
          y_end = (y + rh < eff_h()) ? y + rh : eff_h();
          for (int unsigned col = x; col < x_end; col++)
            for (int unsigned row = y; row < y_end; row++)
              paint(col, row, inv);
        end
        CMD_CLEAR: clear_store();
        default: begin
          if (on_display(x, y)) begin
            res.in_bounds = 1'b1;
            res.read_byte = store[page_index(x, y)];
          end
        end
      endcase
      pending_results.insert(pending_results.size(), res);
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= 100) $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_result(logic [7:0] rd, logic inb);
      page_result_t want;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result read_byte %02h in_bounds %0b", rd, inb));
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      if (rd !== want.read_byte)
        flag_mismatch($sformatf("read_byte %02h, expected %02h", rd, want.read_byte));
      if (inb !== want.in_bounds)
        flag_mismatch($sformatf("in_bounds %0b, expected %0b", inb, want.in_bounds));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_index = 1'b0;
  logic [7:0]           cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  page_store_model model;
  bit              no_gaps = 1'b0;
  bit              hold_ask = 1'b0;
  int              hold_left = 0;
  int              idle_cycles = 0;
  int              cmd_count[4] = '{0, 0, 0, 0};
  int              geometries = 1;

  page_framebuffer_draw_engine DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random back-pressure, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_ask) begin
      hold_left = LONG_HOLD;
      hold_ask  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (no_gaps) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= 7);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      model.check_result(m_axis_tdata, m_axis_tuser);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without a handshake", idle_cycles);
      $display("page_framebuffer_draw_engine verification failed");
      $finish;
    end
  end

  task automatic send_request(cmd_t cmd, logic [6:0] x, logic [5:0] y, logic [7:0] rw,
                              logic [6:0] rh, logic inv);
    int gap;
    gap = 0;
    if (!no_gaps && $urandom_range(0, 99) < 7) gap = $urandom_range(1, 4);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, rh, rw, y, x};
    s_axis_tuser  <= {inv, cmd};
    do @(posedge clk); while (!s_axis_tready);
    model.note_request(cmd, x, y, rw, rh, inv);
    cmd_count[cmd]++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (model.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_config(reg_idx_t idx, logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    model.write_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(logic [7:0] w, logic [7:0] h);
    drain_results();
    write_config(REG_DISP_WIDTH, w);
    write_config(REG_DISP_HEIGHT, h);
    geometries++;
  endtask

  task automatic random_request();
    cmd_t        cmd;
    logic [6:0]  x;
    logic [5:0]  y;
    logic [7:0]  rw;
    logic [6:0]  rh;
    logic        inv;
    int unsigned ew;
    int unsigned eh;
    int          pick;
    ew   = model.eff_w();
    eh   = model.eff_h();
    pick = $urandom_range(0, 99);
    if (pick < 40) cmd = CMD_PIXEL;
    else if (pick < 60) cmd = CMD_RECT;
    else if (pick < 63) cmd = CMD_CLEAR;
    else cmd = CMD_READ;
    // mostly on the display so reads see drawn bytes
    if (ew > 0 && $urandom_range(0, 99) < 75) x = 7'($urandom_range(0, ew - 1));
    else x = 7'($urandom_range(0, 127));
    if (eh > 0 && $urandom_range(0, 99) < 75) y = 6'($urandom_range(0, eh - 1));
    else y = 6'($urandom_range(0, 63));
    if ($urandom_range(0, 99) < 4) begin
      rw = 8'($urandom_range(0, 255));
      rh = 7'($urandom_range(0, 127));
    end else begin
      rw = 8'($urandom_range(0, 12));
      rh = 7'($urandom_range(0, 12));
    end
    inv = ($urandom_range(0, 99) < 30);
    send_request(cmd, x, y, rw, rh, inv);
  endtask

  initial begin
    int         item_no;
    logic [7:0] w;
    logic [7:0] h;
    model = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset geometry 128 x 64, store starts cleared
    send_request(CMD_READ, 7'd0, 6'd0, 8'd0, 7'd0, 1'b0);
    send_request(CMD_PIXEL, 7'd0, 6'd0, 8'd0, 7'd0, 1'b0);
    send_request(CMD_PIXEL, 7'd127, 6'd63, 8'd0, 7'd0, 1'b0);
    send_request(CMD_READ, 7'd0, 6'd0, 8'd0, 7'd0, 1'b0);
    send_request(CMD_READ, 7'd127, 6'd63, 8'd0, 7'd0, 1'b0);
    send_request(CMD_RECT, 7'd120, 6'd60, 8'd20, 7'd10, 1'b0);
    send_request(CMD_READ, 7'd127, 6'd56, 8'd0, 7'd0, 1'b0);
    send_request(CMD_RECT, 7'd0, 6'd0, 8'd0, 7'd5, 1'b1);
    send_request(CMD_RECT, 7'd0, 6'd0, 8'd5, 7'd0, 1'b1);
    send_request(CMD_READ, 7'd0, 6'd0, 8'd0, 7'd0, 1'b0);
    send_request(CMD_PIXEL, 7'd0, 6'd0, 8'd0, 7'd0, 1'b1);
    send_request(CMD_RECT, 7'd0, 6'd0, 8'd255, 7'd127, 1'b0);
    send_request(CMD_READ, 7'd64, 6'd32, 8'd0, 7'd0, 1'b0);
    send_request(CMD_CLEAR, 7'd127, 6'd63, 8'd255, 7'd127, 1'b1);
    send_request(CMD_READ, 7'd127, 6'd63, 8'd0, 7'd0, 1'b0);

    // zero geometry: nothing lies on the display
    set_geometry(8'd0, 8'd0);
    send_request(CMD_PIXEL, 7'd0, 6'd0, 8'd0, 7'd0, 1'b0);
    send_request(CMD_RECT, 7'd0, 6'd0, 8'd10, 7'd10, 1'b0);
    send_request(CMD_READ, 7'd0, 6'd0, 8'd0, 7'd0, 1'b0);

    // oversized geometry clamps to the store size
    set_geometry(8'd255, 8'd255);
    send_request(CMD_PIXEL, 7'd127, 6'd63, 8'd0, 7'd0, 1'b0);
    send_request(CMD_READ, 7'd127, 6'd63, 8'd0, 7'd0, 1'b0);

    // narrowest display, one page high
    set_geometry(8'd1, 8'd8);
    send_request(CMD_PIXEL, 7'd1, 6'd0, 8'd0, 7'd0, 1'b0);
    send_request(CMD_PIXEL, 7'd0, 6'd7, 8'd0, 7'd0, 1'b0);
    send_request(CMD_RECT, 7'd0, 6'd0, 8'd4, 7'd16, 1'b0);
    send_request(CMD_READ, 7'd0, 6'd7, 8'd0, 7'd0, 1'b0);
    send_request(CMD_READ, 7'd0, 6'd8, 8'd0, 7'd0, 1'b0);

    item_no = 0;
    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0: w = 8'($urandom_range(0, 255));
        1: w = 8'd128;
        default: w = 8'($urandom_range(1, 128));
      endcase
      case ($urandom_range(0, 5))
        0: h = 8'($urandom_range(0, 255));
        1: h = 8'd64;
        default: h = 8'($urandom_range(8, 64));
      endcase
      set_geometry(w, h);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        no_gaps = (item_no >= 300 && item_no < 450);
        if (item_no == 600) hold_ask = 1'b1;
        if ($urandom_range(0, 99) == 0) drain_results();
        random_request();
        item_no++;
      end
    end
    no_gaps = 1'b0;

    drain_results();
    repeat (20) @(posedge clk);
    $display("covered %0d requests over %0d geometries: pixel %0d, rect %0d, clear %0d, read %0d",
             cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3], geometries,
             cmd_count[CMD_PIXEL], cmd_count[CMD_RECT], cmd_count[CMD_CLEAR],
             cmd_count[CMD_READ]);
    $display("%0d results checked, %0d mismatches", model.results_checked, model.mismatches);
    if (model.mismatches == 0 && model.pending_results.size() == 0)
      $display("page_framebuffer_draw_engine verification clean");
    else
      $display("page_framebuffer_draw_engine verification failed");
    $finish;
  end

endmodule

// File: page_framebuffer_draw_engine.f
src/pfde_pkg.sv
src/pfde_ram.sv
src/page_framebuffer_draw_engine.sv
dv/tb_page_framebuffer_draw_engine.sv
